>>> rtl/bfel_pkg.sv
// ----------------------------------------------------------------------------
// bfel_pkg
// Shared types and constants of the battery full/empty latch.
// ----------------------------------------------------------------------------
package bfel_pkg;

  localparam int unsigned QualifyTicks = 3;
  localparam int unsigned CntW         = $clog2(QualifyTicks + 1);
  localparam logic [CntW-1:0] QualifyCnt = CntW'(QualifyTicks);

  localparam int unsigned AhW    = 16;
  localparam int unsigned MvW    = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StW    = 2;

  // total / 10 by reciprocal: (x * 52429) >> 19, exact for 16-bit x
  localparam int unsigned RecipW     = 16;
  localparam logic [RecipW-1:0] Recip10 = 16'd52429;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = AhW + RecipW;
  localparam int unsigned AllW       = ProdW - RecipShift;

  localparam int unsigned ScaleW = 10;
  localparam logic [ScaleW-1:0] Permille = 10'd1000;
  localparam int unsigned NumW   = AhW + ScaleW;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned StepW  = $clog2(DivSteps);

  localparam int unsigned ChgW = 8;
  localparam logic [ChgW-1:0] ChgZeroDiv = 8'hFF;

  localparam logic [StW-1:0] ST_NORMAL = 2'd0;
  localparam logic [StW-1:0] ST_FULL   = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_FULL_CLEAR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EMPTY_CLEAR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE     = 2'd2;

  typedef struct packed {
    logic           clear_request;
    logic           system_initializing;
    logic           slaves_ready;
    logic           over_volt_flag;
    logic           under_volt_flag;
    logic [AhW-1:0] discharged_ah;
    logic [AhW-1:0] charged_ah;
    logic [AhW-1:0] total_capacity;
    logic [MvW-1:0] max_cell_mv;
    logic [MvW-1:0] min_cell_mv;
    logic           current_idle;
  } in_item_t;

  typedef struct packed {
    logic [StW-1:0] battery_state;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    value;
  } cfg_wr_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

endpackage

>>> rtl/bfel_if.sv
// ----------------------------------------------------------------------------
// bfel_if
// Valid/ready channels of the battery full/empty latch.
// ----------------------------------------------------------------------------
interface bfel_in_if;
  logic                valid;
  logic                ready;
  bfel_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfel_out_if;
  logic                valid;
  logic                ready;
  bfel_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfel_cfg_if;
  logic              valid;
  logic              ready;
  bfel_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/battery_full_empty_latch.sv
// ----------------------------------------------------------------------------
// battery_full_empty_latch
// Qualifies over/under-voltage flags per tick and latches full or empty.
// ----------------------------------------------------------------------------
//  port   dir  payload                 transfer
//  cfg_i  in   index, value            valid && ready (ready held high)
//  in_i   in   tick inputs             valid && ready (ready in idle only)
//  out_o  out  battery_state           valid && ready
//
//  A tick goes from transfer to result through operand set-up, then
//  a 26-step restoring divider (one quotient bit a cycle), then commit.
//  The commit waits while a previous result has not been taken; the next
//  tick is taken once the commit is done, while the result may still wait.
//  Reset clears latch state, counters and record, and loads config defaults.
// ----------------------------------------------------------------------------
module battery_full_empty_latch (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfel_cfg_if.sink    cfg_i,
  bfel_in_if.sink     in_i,
  bfel_out_if.source  out_o
);

  bfel_pkg::cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  bfel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  bfel_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_data_i       (in_i.data),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .battery_state_o (out_o.data.battery_state)
  );

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_o.valid || out_o.ready))
    else $error("commit while result still pending");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.commit))
    else $error("result raised without commit");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while busy");

  a_state_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.battery_state != 2'd3))
    else $error("invalid battery state");

endmodule

>>> rtl/bfel_ctrl.sv
// ----------------------------------------------------------------------------
// bfel_ctrl
// Sequencer: accept, prepare operands, serial divide, commit one tick.
// ----------------------------------------------------------------------------
module bfel_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfel_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_DINIT  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  localparam logic [bfel_pkg::StepW-1:0] LastStep =
    bfel_pkg::StepW'(bfel_pkg::DivSteps - 1);

  logic [2:0]                 state_q, state_d;
  logic [bfel_pkg::StepW-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic                       commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign commit      = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_valid_i && in_ready_o;
    cmd_o.prep     = (state_q == S_PREP);
    cmd_o.div_init = (state_q == S_DINIT);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.commit   = commit;
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_DINIT;
      end
      S_DINIT: begin
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/bfel_dpath.sv
// ----------------------------------------------------------------------------
// bfel_dpath
// Latch state, configuration, operand registers and restoring divider.
// ----------------------------------------------------------------------------
module bfel_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfel_pkg::cmd_t                cmd_i,
  input  bfel_pkg::in_item_t            in_data_i,
  input  logic                          cfg_we_i,
  input  bfel_pkg::cfg_wr_t             cfg_data_i,
  output logic [bfel_pkg::StW-1:0]      battery_state_o
);

  logic [bfel_pkg::CfgW-1:0] full_clear_q, empty_clear_q, release_q;

  logic [bfel_pkg::StW-1:0]  status_q, status_d;
  logic [bfel_pkg::CntW-1:0] high_q, high_d, low_q, low_d;
  logic [bfel_pkg::AhW-1:0]  rec_q, rec_d;

  bfel_pkg::in_item_t        item_q;
  logic [bfel_pkg::AllW-1:0] all_q;
  logic [bfel_pkg::AhW-1:0]  diff_q;
  logic [bfel_pkg::NumW-1:0] num_q;
  logic [bfel_pkg::AllW-1:0] rem_q;

  logic [bfel_pkg::ProdW-1:0] prod;
  logic [bfel_pkg::AhW-1:0]   now_ah;
  logic [bfel_pkg::AllW:0]    rem_sh;
  logic                       ge;
  logic [bfel_pkg::ChgW-1:0]  chg;
  logic                       chg_hit;
  logic                       reset_all;

  assign battery_state_o = status_q;

  // operand preparation
  assign prod   = item_q.total_capacity * bfel_pkg::Recip10;
  assign now_ah = (status_q == bfel_pkg::ST_EMPTY) ? item_q.charged_ah : item_q.discharged_ah;

  // one quotient bit per step
  assign rem_sh = {rem_q, num_q[bfel_pkg::NumW-1]};
  assign ge     = (rem_sh >= {1'b0, all_q});

  assign chg     = (all_q == '0) ? bfel_pkg::ChgZeroDiv : num_q[bfel_pkg::ChgW-1:0];
  assign chg_hit = ({{(bfel_pkg::CfgW - bfel_pkg::ChgW){1'b0}}, chg} >= release_q);

  assign reset_all = item_q.system_initializing || !item_q.slaves_ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.prep) begin
      all_q  <= prod[bfel_pkg::ProdW-1:bfel_pkg::RecipShift];
      diff_q <= (now_ah > rec_q) ? (now_ah - rec_q) : '0;
    end
    if (cmd_i.div_init) begin
      num_q <= diff_q * bfel_pkg::Permille;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[bfel_pkg::NumW-2:0], ge};
      rem_q <= ge ? bfel_pkg::AllW'(rem_sh - {1'b0, all_q})
                  : rem_sh[bfel_pkg::AllW-1:0];
    end
  end

  always_comb begin
    status_d = status_q;
    high_d   = high_q;
    low_d    = low_q;
    rec_d    = rec_q;
    if (reset_all) begin
      status_d = bfel_pkg::ST_NORMAL;
      high_d   = '0;
      low_d    = '0;
      rec_d    = '0;
    end else if (item_q.clear_request) begin
      status_d = bfel_pkg::ST_NORMAL;
    end else if (item_q.over_volt_flag && !item_q.under_volt_flag) begin
      low_d = '0;
      if (high_q >= bfel_pkg::QualifyCnt) begin
        high_d = bfel_pkg::QualifyCnt;
        if (status_q != bfel_pkg::ST_EMPTY) begin
          status_d = bfel_pkg::ST_FULL;
          rec_d    = item_q.discharged_ah;
        end
      end else begin
        high_d = high_q + 1'b1;
      end
    end else if (item_q.under_volt_flag && !item_q.over_volt_flag) begin
      high_d = '0;
      if (low_q >= bfel_pkg::QualifyCnt) begin
        low_d = bfel_pkg::QualifyCnt;
        if (status_q != bfel_pkg::ST_FULL) begin
          status_d = bfel_pkg::ST_EMPTY;
          rec_d    = item_q.charged_ah;
        end
      end else begin
        low_d = low_q + 1'b1;
      end
    end else begin
      high_d = '0;
      low_d  = '0;
      if (status_q == bfel_pkg::ST_FULL) begin
        if ((item_q.max_cell_mv <= full_clear_q) && item_q.current_idle) begin
          status_d = bfel_pkg::ST_NORMAL;
        end else if (chg_hit) begin
          status_d = bfel_pkg::ST_NORMAL;
        end
      end else if (status_q == bfel_pkg::ST_EMPTY) begin
        if ((item_q.min_cell_mv >= empty_clear_q) && item_q.current_idle) begin
          status_d = bfel_pkg::ST_NORMAL;
        end else if (chg_hit) begin
          status_d = bfel_pkg::ST_NORMAL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= bfel_pkg::ST_NORMAL;
      high_q   <= '0;
      low_q    <= '0;
      rec_q    <= '0;
    end else if (cmd_i.commit) begin
      status_q <= status_d;
      high_q   <= high_d;
      low_q    <= low_d;
      rec_q    <= rec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_clear_q  <= 16'd0;
      empty_clear_q <= 16'd65535;
      release_q     <= 16'd30;
    end else if (cfg_we_i) begin
      case (cfg_data_i.index)
        bfel_pkg::CFG_FULL_CLEAR:  full_clear_q  <= cfg_data_i.value;
        bfel_pkg::CFG_EMPTY_CLEAR: empty_clear_q <= cfg_data_i.value;
        bfel_pkg::CFG_RELEASE:     release_q     <= cfg_data_i.value;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> bench/bfel_latch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfel_latch_checker
// Watches the configuration, tick and result channels of the battery
// full/empty latch, predicts the battery state after every accepted tick
// and compares each result transfer with the oldest prediction in order.
// ----------------------------------------------------------------------------
module bfel_latch_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfel_cfg_if         cfg_ch,
  bfel_in_if          in_ch,
  bfel_out_if         out_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import bfel_pkg::*;

  logic [CfgW-1:0] full_clear_mv;
  logic [CfgW-1:0] empty_clear_mv;
  logic [CfgW-1:0] release_permille;

  logic [StW-1:0]  latch_st;
  logic [CntW-1:0] high_cnt;
  logic [CntW-1:0] low_cnt;
  logic [AhW-1:0]  rec_ah;

  logic [StW-1:0]  expected_state_q[$];
  logic [StW-1:0]  exp_st;
  int unsigned     fails = 0;
  int unsigned     pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic logic [ChgW-1:0] permille_moved(logic [AhW-1:0] now_ah,
                                                     logic [AhW-1:0] total,
                                                     logic [AhW-1:0] since_ah);
    logic [31:0] now32;
    logic [31:0] all32;
    logic [31:0] q;
    now32 = 32'(now_ah);
    if (now32 < 32'(since_ah)) begin
      now32 = 32'(since_ah);
    end
    all32 = 32'(total) / 32'd10;
    if (all32 == 32'd0) begin
      return 8'hFF;
    end
    q = ((now32 - 32'(since_ah)) * 32'd1000) / all32;
    return q[ChgW-1:0];
  endfunction

  task automatic predict_tick(input in_item_t t);
    if (t.system_initializing || !t.slaves_ready) begin
      latch_st = ST_NORMAL;
      high_cnt = '0;
      low_cnt  = '0;
      rec_ah   = '0;
    end else if (t.clear_request) begin
      latch_st = ST_NORMAL;
    end else if (t.over_volt_flag && !t.under_volt_flag) begin
      low_cnt = '0;
      if (high_cnt >= QualifyCnt) begin
        high_cnt = QualifyCnt;
        if (latch_st != ST_EMPTY) begin
          latch_st = ST_FULL;
          rec_ah   = t.discharged_ah;
        end
      end else begin
        high_cnt = high_cnt + 1'b1;
      end
    end else if (t.under_volt_flag && !t.over_volt_flag) begin
      high_cnt = '0;
      if (low_cnt >= QualifyCnt) begin
        low_cnt = QualifyCnt;
        if (latch_st != ST_FULL) begin
          latch_st = ST_EMPTY;
          rec_ah   = t.charged_ah;
        end
      end else begin
        low_cnt = low_cnt + 1'b1;
      end
    end else begin
      high_cnt = '0;
      low_cnt  = '0;
      if (latch_st == ST_FULL) begin
        if (t.max_cell_mv <= full_clear_mv && t.current_idle) begin
          latch_st = ST_NORMAL;
        end else if ({8'h00, permille_moved(t.discharged_ah, t.total_capacity, rec_ah)}
                     >= release_permille) begin
          latch_st = ST_NORMAL;
        end
      end else if (latch_st == ST_EMPTY) begin
        if (t.min_cell_mv >= empty_clear_mv && t.current_idle) begin
          latch_st = ST_NORMAL;
        end else if ({8'h00, permille_moved(t.charged_ah, t.total_capacity, rec_ah)}
                     >= release_permille) begin
          latch_st = ST_NORMAL;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_clear_mv    = 16'd0;
      empty_clear_mv   = 16'd65535;
      release_permille = 16'd30;
      latch_st         = ST_NORMAL;
      high_cnt         = '0;
      low_cnt          = '0;
      rec_ah           = '0;
      expected_state_q.delete();
      pending          = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_state_q.size() == 0) begin
          $error("battery_state: unexpected transfer, expected none, actual %0d",
                 out_ch.data.battery_state);
          fails++;
        end else begin
          exp_st = expected_state_q.pop_front();
          if (out_ch.data.battery_state !== exp_st) begin
            $error("battery_state: expected %0d, actual %0d",
                   exp_st, out_ch.data.battery_state);
            fails++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          CFG_FULL_CLEAR:  full_clear_mv    = cfg_ch.data.value;
          CFG_EMPTY_CLEAR: empty_clear_mv   = cfg_ch.data.value;
          CFG_RELEASE:     release_permille = cfg_ch.data.value;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_tick(in_ch.data);
        expected_state_q.push_back(latch_st);
      end
      pending = expected_state_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the battery full/empty latch with a directed sequence through
// qualification, latching, blocked switching, release by capacity from full
// and by voltage from empty, then random flag runs and drifting amp-hours under
// several register settings, while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  import bfel_pkg::*;

  logic clk_i;
  logic rst_ni;

  bfel_cfg_if cfg_ch ();
  bfel_in_if  in_ch ();
  bfel_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;

  battery_full_empty_latch u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bfel_latch_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_ch       (cfg_ch),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // result-side stall pattern
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned stall_left;

  initial begin
    out_ch.ready = 1'b0;
    stall_mode   = 0;
    mode_left    = 0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 60);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  logic [CfgW-1:0] cur_full_mv;
  logic [CfgW-1:0] cur_empty_mv;
  logic [AhW-1:0]  dhg_base;
  logic [AhW-1:0]  chg_base;
  int unsigned     flag_mode;
  int unsigned     run_left;
  int unsigned     burst_left;

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_wr_t w;
    w.index = idx;
    w.value = val;
    cfg_ch.data  <= w;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    if (idx == CFG_FULL_CLEAR) cur_full_mv = val;
    if (idx == CFG_EMPTY_CLEAR) cur_empty_mv = val;
  endtask

  task automatic set_limits(input logic [CfgW-1:0] full_mv, input logic [CfgW-1:0] empty_mv,
                            input logic [CfgW-1:0] rel);
    write_reg(CFG_FULL_CLEAR, full_mv);
    write_reg(CFG_EMPTY_CLEAR, empty_mv);
    write_reg(CFG_RELEASE, rel);
    cfg_ch.valid <= 1'b0;
  endtask

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_tick(input in_item_t t, input int unsigned gap);
    in_ch.data  <= t;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic in_item_t mk_tick(logic clr, logic init, logic rdy, logic ov, logic uv,
                                       logic [15:0] dhg, logic [15:0] chg, logic [15:0] tot,
                                       logic [15:0] mx, logic [15:0] mn, logic idle);
    in_item_t t;
    t.clear_request       = clr;
    t.system_initializing = init;
    t.slaves_ready        = rdy;
    t.over_volt_flag      = ov;
    t.under_volt_flag     = uv;
    t.discharged_ah       = dhg;
    t.charged_ah          = chg;
    t.total_capacity      = tot;
    t.max_cell_mv         = mx;
    t.min_cell_mv         = mn;
    t.current_idle        = idle;
    return t;
  endfunction

  function automatic logic [15:0] near_mv(logic [15:0] v);
    int x;
    x = int'(v) + int'($urandom_range(0, 40)) - 20;
    if (x < 0) x = 0;
    if (x > 65535) x = 65535;
    return 16'(x);
  endfunction

  task automatic gen_tick(output in_item_t t);
    int unsigned r;
    t = '0;
    if (run_left == 0) begin
      flag_mode = $urandom_range(0, 9);
      run_left  = $urandom_range(1, 8);
    end
    run_left--;
    r = $urandom_range(0, 99);
    t.system_initializing = (r < 2);
    t.slaves_ready        = !(r >= 2 && r < 4);
    t.clear_request       = (r >= 4 && r < 7);
    if (flag_mode <= 3) begin
      t.over_volt_flag = 1'b1;
    end else if (flag_mode <= 6) begin
      t.under_volt_flag = 1'b1;
    end else if (flag_mode == 9) begin
      t.over_volt_flag  = 1'b1;
      t.under_volt_flag = 1'b1;
    end
    if ($urandom_range(0, 19) == 0) t.over_volt_flag = ~t.over_volt_flag;
    if ($urandom_range(0, 19) == 0) t.under_volt_flag = ~t.under_volt_flag;

    dhg_base = dhg_base + 16'($urandom_range(0, 5));
    chg_base = chg_base + 16'($urandom_range(0, 5));
    if ($urandom_range(0, 31) == 0) dhg_base = 16'($urandom);
    if ($urandom_range(0, 31) == 0) chg_base = 16'($urandom);
    t.discharged_ah = ($urandom_range(0, 15) == 0) ? 16'($urandom) : dhg_base;
    t.charged_ah    = ($urandom_range(0, 15) == 0) ? 16'($urandom) : chg_base;

    r = $urandom_range(0, 9);
    if (r == 0) t.total_capacity = 16'($urandom_range(0, 9));
    else if (r == 1) t.total_capacity = 16'($urandom);
    else t.total_capacity = 16'($urandom_range(100, 3000));

    r = $urandom_range(0, 3);
    t.max_cell_mv = (r < 2) ? near_mv(cur_full_mv) : 16'($urandom);
    r = $urandom_range(0, 3);
    t.min_cell_mv = (r < 2) ? near_mv(cur_empty_mv) : 16'($urandom);
    t.current_idle = ($urandom_range(0, 9) < 7);
  endtask

  task automatic run_random(input int unsigned count);
    in_item_t    t;
    int unsigned gap;
    repeat (count) begin
      gen_tick(t);
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 45);
      end
      burst_left--;
      send_tick(t, gap);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic run_directed();
    // qualification resets
    send_tick(mk_tick(1, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1), 0);
    send_tick(mk_tick(0, 0, 0, 0, 0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0), 3);
    // qualify and latch full, then hold with a refreshed record
    repeat (4) send_tick(mk_tick(0, 0, 1, 1, 0, 16'd100, 16'd0, 16'd1000, 16'd4200,
                                 16'd3500, 0), 0);
    send_tick(mk_tick(0, 0, 1, 1, 0, 16'd120, 16'd0, 16'd1000, 16'd4200, 16'd3500, 0), 0);
    // empty qualification must not override full
    repeat (4) send_tick(mk_tick(0, 0, 1, 0, 1, 16'd120, 16'd50, 16'd1000, 16'd4200,
                                 16'd2500, 1), 1);
    // at the clear limit but not idle, then capacity just under and at threshold
    send_tick(mk_tick(0, 0, 1, 0, 0, 16'd120, 16'd50, 16'd1000, 16'd3400, 16'd3500, 0), 0);
    send_tick(mk_tick(0, 0, 1, 0, 0, 16'd122, 16'd50, 16'd1000, 16'd4000, 16'd3500, 1), 0);
    send_tick(mk_tick(0, 0, 1, 0, 0, 16'd123, 16'd50, 16'd1000, 16'd4000, 16'd3500, 1), 2);
    // full at the top record, both flags act as neither
    repeat (4) send_tick(mk_tick(0, 0, 1, 1, 0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF,
                                 16'd3500, 0), 0);
    send_tick(mk_tick(0, 0, 1, 1, 1, 16'd10, 16'd0, 16'hFFFF, 16'hFFFF, 16'd3500, 0), 0);
    send_tick(mk_tick(0, 0, 1, 1, 1, 16'd10, 16'd0, 16'd9, 16'hFFFF, 16'd3500, 0), 0);
    // empty, clear request, immediate relatch with saturated counter
    repeat (4) send_tick(mk_tick(0, 0, 1, 0, 1, 16'd0, 16'd500, 16'd1000, 16'd3500,
                                 16'd2000, 0), 0);
    send_tick(mk_tick(1, 0, 1, 0, 1, 16'd0, 16'd550, 16'd1000, 16'd3500, 16'd2000, 0), 0);
    send_tick(mk_tick(0, 0, 1, 0, 1, 16'd0, 16'd600, 16'd1000, 16'd3500, 16'd2000, 0), 0);
    // change wraps in 8 bits, then voltage release when idle
    send_tick(mk_tick(0, 0, 1, 0, 0, 16'd0, 16'd626, 16'd1000, 16'd3500, 16'd2000, 1), 0);
    send_tick(mk_tick(0, 0, 1, 0, 0, 16'd0, 16'd626, 16'd1000, 16'd3500, 16'd3000, 1), 0);
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cur_full_mv  = 16'd0;
    cur_empty_mv = 16'd65535;
    dhg_base     = '0;
    chg_base     = '0;
    flag_mode    = 0;
    run_left     = 0;
    burst_left   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_limits(16'd3400, 16'd3000, 16'd30);
    run_directed();
    drain();

    set_limits(16'd0, 16'd65535, 16'd0);
    run_random(200);
    drain();

    set_limits(16'd65535, 16'd0, 16'd65535);
    run_random(200);
    drain();

    set_limits(16'($urandom_range(3000, 4300)), 16'($urandom_range(2500, 3500)),
               16'($urandom_range(1, 60)));
    run_random(200);
    drain();

    set_limits(16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)));
    run_random(200);
    drain();

    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bfel_pkg.sv
rtl/bfel_if.sv
rtl/bfel_ctrl.sv
rtl/bfel_dpath.sv
rtl/battery_full_empty_latch.sv
bench/bfel_latch_checker.sv
bench/testbench.sv
